FILE: hdl/odr_pkg.sv
// odr_pkg: shared types, side masks and the masking helper for the
// opposing direction resolver; no dependencies
`default_nettype none

package odr_pkg;

   typedef logic [7:0] key_mask_type;

   typedef enum logic [1:0] {
      WIN_NONE = 2'd0,
      WIN_NEG  = 2'd1,
      WIN_POS  = 2'd2
   } win_type;

   // bit order clockwise from up
   localparam key_mask_type SIDE_UP    = 8'h83;
   localparam key_mask_type SIDE_DOWN  = 8'h38;
   localparam key_mask_type SIDE_LEFT  = 8'hE0;
   localparam key_mask_type SIDE_RIGHT = 8'h0E;

   function automatic key_mask_type drop_loser(input key_mask_type mask,
                                               input win_type win,
                                               input key_mask_type first_side,
                                               input key_mask_type second_side);
      key_mask_type res;
      case (win)
         WIN_NEG: begin
            res = mask & ~second_side;
         end
         WIN_POS: begin
            res = mask & ~first_side;
         end
         default: begin
            res = mask;
         end
      endcase
      return res;
   endfunction

endpackage

`default_nettype wire

FILE: hdl/odr_chan_if.sv
// odr_req_if / odr_rsp_if: valid-ready channels carrying one key mask word
// depends on odr_pkg
`default_nettype none

interface odr_req_if import odr_pkg::*; ();
   logic         valid;
   logic         ready;
   key_mask_type held_keys;

   modport source (output valid, output held_keys, input ready);
   modport sink   (input valid, input held_keys, output ready);
endinterface

interface odr_rsp_if import odr_pkg::*; ();
   logic         valid;
   logic         ready;
   key_mask_type resolved_mask;

   modport source (output valid, output resolved_mask, input ready);
   modport sink   (input valid, input resolved_mask, output ready);
endinterface

`default_nettype wire

FILE: hdl/odr_axis.sv
// odr_axis: priority decision for one axis from held keys and rising edges
// depends on odr_pkg
`default_nettype none

module odr_axis import odr_pkg::*; (
   input  key_mask_type held,
   input  key_mask_type fresh,
   input  key_mask_type first_side,
   input  key_mask_type second_side,
   input  win_type      kept,
   output win_type      winner
);

   logic conflict;
   logic neg_fresh;
   logic pos_fresh;

   assign conflict  = (|(held & first_side)) && (|(held & second_side));
   assign neg_fresh = |(fresh & first_side);
   assign pos_fresh = |(fresh & second_side);

   always_comb begin
      if (!conflict || (neg_fresh && pos_fresh)) begin
         winner = WIN_NONE;
      end else if (neg_fresh) begin
         winner = WIN_NEG;
      end else if (pos_fresh) begin
         winner = WIN_POS;
      end else begin
         winner = kept;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/opposing_direction_resolver.sv
// opposing_direction_resolver: from accept to result valid,
// the word passes an input register and a result register
// throughput one word per cycle while the receiver takes results, set by the input and result registers
// synchronous reset clears previous sample, both winners and the valid flags
// depends on odr_pkg, odr_chan_if, odr_axis
`default_nettype none

module opposing_direction_resolver import odr_pkg::*; (
   input wire logic  clock,
   input wire logic  reset,
   odr_req_if.sink   req_chan,
   odr_rsp_if.source rsp_chan
);

   logic         in_valid_ff;
   key_mask_type in_mask_ff;
   logic         out_valid_ff;
   key_mask_type out_mask_ff;
   key_mask_type prev_ff;
   win_type      vert_ff;
   win_type      horz_ff;

   logic         out_adv;
   logic         in_adv;
   key_mask_type fresh;
   win_type      vert_in;
   win_type      horz_in;
   key_mask_type res_in;

   assign out_adv = !out_valid_ff || rsp_chan.ready;
   assign in_adv  = in_valid_ff && out_adv;

   assign req_chan.ready        = !in_valid_ff || out_adv;
   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.resolved_mask = out_mask_ff;

   assign fresh = in_mask_ff & ~prev_ff;

   odr_axis u_vert (
      .held        (in_mask_ff),
      .fresh       (fresh),
      .first_side  (SIDE_UP),
      .second_side (SIDE_DOWN),
      .kept        (vert_ff),
      .winner      (vert_in)
   );

   odr_axis u_horz (
      .held        (in_mask_ff),
      .fresh       (fresh),
      .first_side  (SIDE_LEFT),
      .second_side (SIDE_RIGHT),
      .kept        (horz_ff),
      .winner      (horz_in)
   );

   assign res_in = drop_loser(drop_loser(in_mask_ff, vert_in, SIDE_UP, SIDE_DOWN),
                              horz_in, SIDE_LEFT, SIDE_RIGHT);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         prev_ff      <= '0;
         vert_ff      <= WIN_NONE;
         horz_ff      <= WIN_NONE;
      end else begin
         if (req_chan.ready) begin
            in_valid_ff <= req_chan.valid;
         end
         if (out_adv) begin
            out_valid_ff <= in_valid_ff;
         end
         // state moves only when a word leaves the input register
         if (in_adv) begin
            prev_ff <= in_mask_ff;
            vert_ff <= vert_in;
            horz_ff <= horz_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_mask_ff <= req_chan.held_keys;
      end
      if (in_adv) begin
         out_mask_ff <= res_in;
      end
   end

endmodule

`default_nettype wire

FILE: bench/opposing_direction_resolver_tb.sv
// opposing_direction_resolver_tb: self-checking bench for the opposing direction resolver
// walks a directed table, then random key sequences under varied idling, checked
// against a local last-input-priority predictor; depends on odr_pkg, odr_chan_if, opposing_direction_resolver
`timescale 1ns / 100ps

module opposing_direction_resolver_tb;
   import odr_pkg::*;

   localparam int DUT_LATENCY = 2;
   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_WORDS = 600;
   localparam int PROBE_COUNT = 25;

   typedef struct packed {
      key_mask_type keys;
      bit           known;
      key_mask_type want;
   } probe_row_type;

   logic clock;
   logic reset;

   odr_req_if req_if ();
   odr_rsp_if rsp_if ();

   opposing_direction_resolver u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   // extremes, every special case, then mixed diagonals
   probe_row_type probes [PROBE_COUNT] = '{
      '{8'h00, 1'b1, 8'h00},
      '{8'hFF, 1'b1, 8'hFF},
      '{8'hFF, 1'b1, 8'hFF},
      '{8'h00, 1'b1, 8'h00},
      '{8'h01, 1'b1, 8'h01},
      '{8'h11, 1'b1, 8'h10},
      '{8'h11, 1'b1, 8'h10},
      '{8'h10, 1'b1, 8'h10},
      '{8'h11, 1'b1, 8'h01},
      '{8'h00, 1'b1, 8'h00},
      '{8'h40, 1'b1, 8'h40},
      '{8'h44, 1'b1, 8'h04},
      '{8'h44, 1'b1, 8'h04},
      '{8'h45, 1'b0, 8'h00},
      '{8'h00, 1'b1, 8'h00},
      '{8'h22, 1'b1, 8'h22},
      '{8'h80, 1'b0, 8'h00},
      '{8'h88, 1'b0, 8'h00},
      '{8'h08, 1'b0, 8'h00},
      '{8'h0E, 1'b0, 8'h00},
      '{8'hEE, 1'b0, 8'h00},
      '{8'h38, 1'b0, 8'h00},
      '{8'hBB, 1'b0, 8'h00},
      '{8'h55, 1'b0, 8'h00},
      '{8'hAA, 1'b0, 8'h00}
   };

   key_mask_type last_keys = '0;
   win_type      vert_lead = WIN_NONE;
   win_type      horiz_lead = WIN_NONE;

   key_mask_type resolved_queue [$];
   bit           row_known = 1'b0;
   key_mask_type row_want = '0;
   int           send_idle_pct = 0;
   int           rsp_idle_pct = 0;
   int           hold_cycles = 0;
   int           errors = 0;
   int           words_in = 0;
   int           words_checked = 0;
   int           input_stalls = 0;
   int           cycles = 0;

   function automatic win_type settle_axis(input key_mask_type held,
                                           input key_mask_type rose,
                                           input key_mask_type first_side,
                                           input key_mask_type second_side,
                                           input win_type kept);
      win_type lead;
      if ((held & first_side) == '0 || (held & second_side) == '0) lead = WIN_NONE;
      else if ((rose & first_side) != '0 && (rose & second_side) != '0) lead = WIN_NONE;
      else if ((rose & first_side) != '0) lead = WIN_NEG;
      else if ((rose & second_side) != '0) lead = WIN_POS;
      else lead = kept;
      return lead;
   endfunction

   function automatic key_mask_type resolve_keys(input key_mask_type held);
      key_mask_type rose;
      key_mask_type keys;
      rose = held & ~last_keys;
      vert_lead = settle_axis(held, rose, SIDE_UP, SIDE_DOWN, vert_lead);
      horiz_lead = settle_axis(held, rose, SIDE_LEFT, SIDE_RIGHT, horiz_lead);
      last_keys = held;
      keys = held;
      if (vert_lead == WIN_NEG) keys = keys & ~SIDE_DOWN;
      else if (vert_lead == WIN_POS) keys = keys & ~SIDE_UP;
      if (horiz_lead == WIN_NEG) keys = keys & ~SIDE_RIGHT;
      else if (horiz_lead == WIN_POS) keys = keys & ~SIDE_LEFT;
      return keys;
   endfunction

   // mostly single presses and releases, some chords, some noise
   function automatic key_mask_type next_keys(input key_mask_type cur);
      int pick;
      key_mask_type keys;
      pick = $urandom_range(99);
      if (pick < 55) keys = cur ^ (8'h01 << $urandom_range(7));
      else if (pick < 70) keys = cur;
      else if (pick < 80)
         keys = cur ^ (8'h01 << $urandom_range(7)) ^ (8'h10 << $urandom_range(3));
      else keys = key_mask_type'($urandom_range(255));
      return keys;
   endfunction

   task automatic send_keys(input key_mask_type keys, input bit known,
                            input key_mask_type want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.held_keys <= keys;
      row_known = known;
      row_want = want;
      do @(negedge clock); while (!req_if.ready);
      @(posedge clock);
   endtask

   task automatic drain_results();
      req_if.valid <= 1'b0;
      while (resolved_queue.size() != 0) @(posedge clock);
      repeat (DUT_LATENCY + 2) @(posedge clock);
   endtask

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
         $display("** opposing_direction_resolver: FAILED **");
         $finish;
      end
   end

   // receiver: random stalls plus one long hold-off
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            rsp_if.ready <= 1'b0;
            hold_cycles = hold_cycles - 1;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   // sampled mid-cycle, so the handshake seen here completes at the next edge
   always @(negedge clock) begin
      key_mask_type want;
      if (!reset && req_if.valid && !req_if.ready) input_stalls = input_stalls + 1;
      if (!reset && req_if.valid && req_if.ready) begin
         want = resolve_keys(req_if.held_keys);
         if (row_known) want = row_want;
         resolved_queue.push_back(want);
         words_in = words_in + 1;
      end
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (resolved_queue.size() == 0) begin
            errors = errors + 1;
            $display("%0t: unexpected word, expected none, got %02h", $time,
                     rsp_if.resolved_mask);
         end else begin
            want = resolved_queue.pop_front();
            words_checked = words_checked + 1;
            if (rsp_if.resolved_mask !== want) begin
               errors = errors + 1;
               $display("%0t: resolved_mask mismatch, expected %02h, got %02h", $time,
                        want, rsp_if.resolved_mask);
            end
         end
      end
   end

   initial begin
      key_mask_type keys;
      int           phase;
      int           count;
      keys = '0;
      reset <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.held_keys <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 30;
               rsp_idle_pct = 63;
            end
            1: begin
               send_idle_pct = 63;
               rsp_idle_pct = 30;
            end
            default: begin
               send_idle_pct = 0;
               rsp_idle_pct = 0;
            end
         endcase
         count = PHASE_WORDS;
         if (phase == 0) begin
            foreach (probes[i]) send_keys(probes[i].keys, probes[i].known, probes[i].want);
            keys = probes[PROBE_COUNT - 1].keys;
            count = PHASE_WORDS - PROBE_COUNT;
         end
         for (int i = 0; i < count; i++) begin
            if (phase == 2 && i == 200) hold_cycles = 80;
            keys = next_keys(keys);
            send_keys(keys, 1'b0, '0);
         end
         drain_results();
      end

      $display("run covered %0d key words in three idling phases, %0d results checked",
               words_in, words_checked);
      $display("input held off for %0d cycles, including one long result stall",
               input_stalls);
      if (errors == 0) begin
         $display("** opposing_direction_resolver: PASSED **");
      end else begin
         $display("** opposing_direction_resolver: FAILED **");
      end
      $finish;
   end

endmodule
